### design/saabb_pkg.sv
// Package for the swept box collision-time pipeline.
// Widths of coordinates, doubled box corners and the hit fraction.
// No dependencies.
package saabb_pkg;

    localparam int CoordBits    = 32;
    localparam int SizeBits     = CoordBits - 1;
    localparam int TimeFracBits = 16;
    localparam int FracBits     = TimeFracBits + 1;
    // doubled Minkowski corners and doubled relative motion
    localparam int WideBits     = CoordBits + 3;
    // products of two wide values
    localparam int ProdBits     = 2 * WideBits + 1;

    typedef logic signed [WideBits-1:0] wide_t;
    typedef logic signed [ProdBits-1:0] prod_t;
    typedef logic        [FracBits-1:0] frac_t;

    // One edge test after its range checks: hit candidate and division operands.
    typedef struct packed {
        logic  live;
        wide_t num;
        wide_t den;
    } edge_t;

endpackage

### design/swept_aabb_collision_time.sv
// Top level of the swept box collision-time pipeline.
// Depends on saabb_pkg.

// Takes one moving box and one target box per cycle and returns whether the
// relative motion ray hits the Minkowski difference box within the frame, with
// the earliest hit fraction (unsigned Q1.16, 1.0 when there is no hit).
// Throughput is one item per clock while the output register is not stalled.
// The stages are corner forming, edge setup, product and range
// checks, divider entry, then one quotient bit per stage of the four parallel restoring
// dividers, and a final minimum. All stages advance together when the output
// register is free or being emptied.
module swept_aabb_collision_time (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [saabb_pkg::CoordBits-1:0] s_src_center_x,
    input  logic signed [saabb_pkg::CoordBits-1:0] s_src_center_y,
    input  logic        [saabb_pkg::SizeBits-1:0]  s_src_width,
    input  logic        [saabb_pkg::SizeBits-1:0]  s_src_height,
    input  logic signed [saabb_pkg::CoordBits-1:0] s_src_delta_x,
    input  logic signed [saabb_pkg::CoordBits-1:0] s_src_delta_y,
    input  logic signed [saabb_pkg::CoordBits-1:0] s_tar_center_x,
    input  logic signed [saabb_pkg::CoordBits-1:0] s_tar_center_y,
    input  logic        [saabb_pkg::SizeBits-1:0]  s_tar_width,
    input  logic        [saabb_pkg::SizeBits-1:0]  s_tar_height,
    input  logic signed [saabb_pkg::CoordBits-1:0] s_tar_delta_x,
    input  logic signed [saabb_pkg::CoordBits-1:0] s_tar_delta_y,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_collided,
    output logic        [saabb_pkg::FracBits-1:0]  m_hit_fraction
);
    import saabb_pkg::*;

    localparam int NDiv = TimeFracBits;

    logic adv;

    // stage 1: corners and motion
    logic  v1_reg;
    wide_t lx_reg, ly_reg, ux_reg, uy_reg, dx_reg, dy_reg;
    wide_t lx_next, ly_next, ux_next, uy_next, dx_next, dy_next;

    // stage 2: per-edge normalized operands (left, top, right, bottom)
    logic  v2_reg;
    logic  ok2_reg [4];
    wide_t p2_reg [4], a2_reg [4], t2_reg [4], lo2_reg [4], hi2_reg [4];

    // stage 3: products and range checks
    logic  v3_reg;
    edge_t e3_reg [4];

    // divider stages
    logic  vd_reg [NDiv+1];
    logic  ld_reg [NDiv+1][4];
    logic  full_reg [NDiv+1][4];
    wide_t rem_reg [NDiv+1][4];
    wide_t den_reg [NDiv+1][4];
    logic [TimeFracBits-1:0] q_reg [NDiv+1][4];

    // output register
    logic  m_valid_reg, m_collided_reg;
    frac_t m_frac_reg;

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    // form doubled corners
    always_comb begin
        wide_t tw, sw, th, sh;
        tw = wide_t'({1'b0, s_tar_width});
        sw = wide_t'({1'b0, s_src_width});
        th = wide_t'({1'b0, s_tar_height});
        sh = wide_t'({1'b0, s_src_height});
        lx_next = 2 * wide_t'(s_tar_center_x) - tw - 2 * wide_t'(s_src_center_x) - sw;
        ly_next = 2 * wide_t'(s_tar_center_y) - th - 2 * wide_t'(s_src_center_y) - sh;
        ux_next = 2 * wide_t'(s_tar_center_x) + tw - 2 * wide_t'(s_src_center_x) + sw;
        uy_next = 2 * wide_t'(s_tar_center_y) + th - 2 * wide_t'(s_src_center_y) + sh;
        dx_next = 2 * (wide_t'(s_src_delta_x) - wide_t'(s_tar_delta_x));
        dy_next = 2 * (wide_t'(s_src_delta_y) - wide_t'(s_tar_delta_y));
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            lx_reg <= lx_next;
            ly_reg <= ly_next;
            ux_reg <= ux_next;
            uy_reg <= uy_next;
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
    end

    // edge setup: left, top, right, bottom
    always_ff @(posedge aclk) begin
        wide_t pos [4], lo [4], hi [4], dn [4], dt [4];
        pos[0] = lx_reg; lo[0] = ly_reg; hi[0] = uy_reg; dn[0] = dx_reg; dt[0] = dy_reg;
        pos[1] = uy_reg; lo[1] = lx_reg; hi[1] = ux_reg; dn[1] = dy_reg; dt[1] = dx_reg;
        pos[2] = ux_reg; lo[2] = ly_reg; hi[2] = uy_reg; dn[2] = dx_reg; dt[2] = dy_reg;
        pos[3] = ly_reg; lo[3] = lx_reg; hi[3] = ux_reg; dn[3] = dy_reg; dt[3] = dx_reg;
        if (adv) begin
            for (int e = 0; e < 4; e++) begin
                p2_reg[e]  <= dn[e][WideBits-1] ? -pos[e] : pos[e];
                a2_reg[e]  <= dn[e][WideBits-1] ? -dn[e] : dn[e];
                ok2_reg[e] <= (dn[e] != '0) && (hi[e] != lo[e]);
                t2_reg[e]  <= dt[e];
                lo2_reg[e] <= lo[e];
                hi2_reg[e] <= hi[e];
            end
        end
    end

    // products and range checks
    always_ff @(posedge aclk) begin
        prod_t m, ml, mh;
        logic  in_rng;
        if (adv) begin
            for (int e = 0; e < 4; e++) begin
                m  = prod_t'(p2_reg[e]) * prod_t'(t2_reg[e]);
                ml = prod_t'(lo2_reg[e]) * prod_t'(a2_reg[e]);
                mh = prod_t'(hi2_reg[e]) * prod_t'(a2_reg[e]);
                in_rng = !p2_reg[e][WideBits-1] && (p2_reg[e] <= a2_reg[e]);
                e3_reg[e].live <= ok2_reg[e] && in_rng && (m >= ml) && (m <= mh);
                e3_reg[e].num  <= p2_reg[e];
                e3_reg[e].den  <= a2_reg[e];
            end
        end
    end

    // divider entry
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int e = 0; e < 4; e++) begin
                ld_reg[0][e]   <= e3_reg[e].live;
                full_reg[0][e] <= e3_reg[e].num >= e3_reg[e].den;
                rem_reg[0][e]  <= e3_reg[e].num;
                den_reg[0][e]  <= e3_reg[e].den;
                q_reg[0][e]    <= '0;
            end
        end
    end

    // one quotient bit per stage
    for (genvar k = 0; k < NDiv; k++) begin : g_div
        always_ff @(posedge aclk) begin
            logic [WideBits:0] sh;
            if (adv) begin
                for (int e = 0; e < 4; e++) begin
                    sh = {rem_reg[k][e], 1'b0};
                    ld_reg[k+1][e]   <= ld_reg[k][e];
                    full_reg[k+1][e] <= full_reg[k][e];
                    den_reg[k+1][e]  <= den_reg[k][e];
                    if (sh >= {1'b0, den_reg[k][e]}) begin
                        rem_reg[k+1][e] <= wide_t'(sh - {1'b0, den_reg[k][e]});
                        q_reg[k+1][e]   <= {q_reg[k][e][TimeFracBits-2:0], 1'b1};
                    end else begin
                        rem_reg[k+1][e] <= wide_t'(sh);
                        q_reg[k+1][e]   <= {q_reg[k][e][TimeFracBits-2:0], 1'b0};
                    end
                end
            end
        end
    end

    // valid bits travel with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            for (int k = 0; k <= NDiv; k++) vd_reg[k] <= 1'b0;
        end else if (adv) begin
            v1_reg    <= s_valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            vd_reg[0] <= v3_reg;
            for (int k = 0; k < NDiv; k++) vd_reg[k+1] <= vd_reg[k];
        end
    end

    // earliest hit into the output register
    always_ff @(posedge aclk) begin
        frac_t best, f;
        logic  hit;
        best = frac_t'(1) << TimeFracBits;
        hit  = 1'b0;
        for (int e = 0; e < 4; e++) begin
            f = full_reg[NDiv][e] ? (frac_t'(1) << TimeFracBits)
                                  : frac_t'(q_reg[NDiv][e]);
            if (ld_reg[NDiv][e]) begin
                if (!hit || f < best) best = f;
                hit = 1'b1;
            end
        end
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg    <= vd_reg[NDiv];
            m_collided_reg <= hit;
            m_frac_reg     <= best;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_collided     = m_collided_reg;
    assign m_hit_fraction = m_frac_reg;

`ifndef ASSERT_OFF
    // a stalled output register holds its item
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hit_fraction) && $stable(m_collided))
        else $error("output item changed under stall");
    // no hit means fraction one
    a_nohit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_collided |-> m_hit_fraction == (frac_t'(1) << TimeFracBits))
        else $error("miss with fraction below one");
    // fraction never exceeds one
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_hit_fraction <= (frac_t'(1) << TimeFracBits))
        else $error("fraction above one");
    // ready follows the output register
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");
`endif

endmodule

### bench/saabb_scoreboard.sv
`timescale 1ns / 100ps
// Checker for the swept box collision-time block: predicts each result from the
// accepted box pair and compares it with what the block returns.
// Depends on saabb_pkg.
module saabb_scoreboard (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    input  logic                                   s_ready,
    input  logic signed [saabb_pkg::CoordBits-1:0] s_src_center_x,
    input  logic signed [saabb_pkg::CoordBits-1:0] s_src_center_y,
    input  logic        [saabb_pkg::SizeBits-1:0]  s_src_width,
    input  logic        [saabb_pkg::SizeBits-1:0]  s_src_height,
    input  logic signed [saabb_pkg::CoordBits-1:0] s_src_delta_x,
    input  logic signed [saabb_pkg::CoordBits-1:0] s_src_delta_y,
    input  logic signed [saabb_pkg::CoordBits-1:0] s_tar_center_x,
    input  logic signed [saabb_pkg::CoordBits-1:0] s_tar_center_y,
    input  logic        [saabb_pkg::SizeBits-1:0]  s_tar_width,
    input  logic        [saabb_pkg::SizeBits-1:0]  s_tar_height,
    input  logic signed [saabb_pkg::CoordBits-1:0] s_tar_delta_x,
    input  logic signed [saabb_pkg::CoordBits-1:0] s_tar_delta_y,
    input  logic                                   m_valid,
    input  logic                                   m_ready,
    input  logic                                   m_collided,
    input  logic        [saabb_pkg::FracBits-1:0]  m_hit_fraction,
    output int                                     errors,
    output int                                     pending,
    output int                                     hits_seen,
    output int                                     results_seen
);
    import saabb_pkg::*;

    typedef struct packed {
        logic  collided;
        frac_t fraction;
    } hit_t;

    hit_t hit_queue[$];

    // Test the ray against one edge at normal position pos spanning [lo,hi].
    function automatic void cross_edge(input longint pos, input longint lo, input longint hi,
                                       input longint dn, input longint dt,
                                       inout bit hit, inout longint best);
        longint a, p, f;
        logic signed [127:0] m, mlo, mhi;
        if (dn == 0 || hi == lo) return;
        a = (dn < 0) ? -dn : dn;
        p = (dn < 0) ? -pos : pos;
        if (p < 0 || p > a) return;
        m   = 128'(signed'(p)) * 128'(signed'(dt));
        mlo = 128'(signed'(lo)) * 128'(signed'(a));
        mhi = 128'(signed'(hi)) * 128'(signed'(a));
        if (m < mlo || m > mhi) return;
        // p < a keeps p << TimeFracBits well inside 64 bits
        f = (p >= a) ? (longint'(1) << TimeFracBits) : ((p << TimeFracBits) / a);
        if (!hit || f < best) best = f;
        hit = 1'b1;
    endfunction

    function automatic hit_t earliest_hit();
        longint lx, ly, ux, uy, dx, dy, best;
        bit hit;
        hit_t r;
        lx = 2 * longint'(s_tar_center_x) - longint'(s_tar_width)
           - 2 * longint'(s_src_center_x) - longint'(s_src_width);
        ly = 2 * longint'(s_tar_center_y) - longint'(s_tar_height)
           - 2 * longint'(s_src_center_y) - longint'(s_src_height);
        ux = lx + 2 * (longint'(s_tar_width) + longint'(s_src_width));
        uy = ly + 2 * (longint'(s_tar_height) + longint'(s_src_height));
        dx = 2 * (longint'(s_src_delta_x) - longint'(s_tar_delta_x));
        dy = 2 * (longint'(s_src_delta_y) - longint'(s_tar_delta_y));
        hit = 1'b0;
        best = longint'(1) << TimeFracBits;
        // left, top, right, bottom
        cross_edge(lx, ly, uy, dx, dy, hit, best);
        cross_edge(uy, lx, ux, dy, dx, hit, best);
        cross_edge(ux, ly, uy, dx, dy, hit, best);
        cross_edge(ly, lx, ux, dy, dx, hit, best);
        r.collided = hit;
        r.fraction = frac_t'(best);
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        errors++;
    endtask

    initial begin
        errors = 0;
        hits_seen = 0;
        results_seen = 0;
    end

    assign pending = hit_queue.size();

    // Record predictions on input handshakes, compare on output handshakes.
    always @(posedge aclk) begin
        hit_t got, want;
        if (aresetn) begin
            if (s_valid && s_ready) hit_queue.push_back(earliest_hit());
            if (m_valid && m_ready) begin
                got.collided = m_collided;
                got.fraction = m_hit_fraction;
                results_seen++;
                if (got.collided) hits_seen++;
                if (hit_queue.size() == 0) begin
                    report_mismatch("result with no item outstanding");
                end else begin
                    want = hit_queue.pop_front();
                    if (got.collided !== want.collided)
                        report_mismatch($sformatf("collided %b, predicted %b",
                                                  got.collided, want.collided));
                    if (got.fraction !== want.fraction)
                        report_mismatch($sformatf("hit_fraction %0d, predicted %0d",
                                                  got.fraction, want.fraction));
                end
            end
        end
    end
endmodule

### bench/swept_aabb_collision_time_test.sv
`timescale 1ns / 100ps
// Top of the swept box collision-time bench: clock, reset, box pair stimulus
// with random idling and the verdict. Depends on saabb_pkg, saabb_scoreboard.
module swept_aabb_collision_time_test;
    import saabb_pkg::*;

    localparam int RandomPairs = 850;
    localparam int CycleLimit  = 400000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [CoordBits-1:0] scx = '0, scy = '0, sdx = '0, sdy = '0;
    logic signed [CoordBits-1:0] tcx = '0, tcy = '0, tdx = '0, tdy = '0;
    logic        [SizeBits-1:0]  sw = '0, sh = '0, tw = '0, th = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_collided;
    frac_t m_hit_fraction;
    int errors, pending, hits_seen, results_seen;
    int cycles = 0;
    bit sender_busy = 1'b0;    // zero-gap phase on both sides
    bit hold_outputs = 1'b0;   // request a long output stall

    always #1 aclk = ~aclk;

    swept_aabb_collision_time dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_src_center_x(scx), .s_src_center_y(scy),
        .s_src_width(sw), .s_src_height(sh),
        .s_src_delta_x(sdx), .s_src_delta_y(sdy),
        .s_tar_center_x(tcx), .s_tar_center_y(tcy),
        .s_tar_width(tw), .s_tar_height(th),
        .s_tar_delta_x(tdx), .s_tar_delta_y(tdy),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_collided(m_collided), .m_hit_fraction(m_hit_fraction)
    );

    saabb_scoreboard scoreboard (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_src_center_x(scx), .s_src_center_y(scy),
        .s_src_width(sw), .s_src_height(sh),
        .s_src_delta_x(sdx), .s_src_delta_y(sdy),
        .s_tar_center_x(tcx), .s_tar_center_y(tcy),
        .s_tar_width(tw), .s_tar_height(th),
        .s_tar_delta_x(tdx), .s_tar_delta_y(tdy),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_collided(m_collided), .m_hit_fraction(m_hit_fraction),
        .errors(errors), .pending(pending),
        .hits_seen(hits_seen), .results_seen(results_seen)
    );

    // Abort a hung run.
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CycleLimit) begin
            $display("timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Offer one box pair after a random gap and hold it until accepted.
    task automatic offer_pair(input logic signed [CoordBits-1:0] a_cx, a_cy,
                              input logic [SizeBits-1:0] a_w, a_h,
                              input logic signed [CoordBits-1:0] a_dx, a_dy,
                              input logic signed [CoordBits-1:0] b_cx, b_cy,
                              input logic [SizeBits-1:0] b_w, b_h,
                              input logic signed [CoordBits-1:0] b_dx, b_dy);
        int gap;
        gap = sender_busy ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        scx = a_cx; scy = a_cy; sw = a_w; sh = a_h; sdx = a_dx; sdy = a_dy;
        tcx = b_cx; tcy = b_cy; tw = b_w; th = b_h; tdx = b_dx; tdy = b_dy;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    function automatic logic signed [CoordBits-1:0] near(input int span);
        return CoordBits'($signed($urandom_range(0, 2 * span)) - span);
    endfunction

    // Random pair: mostly boxes close together with motion that reaches them.
    task automatic offer_random_pair();
        logic signed [CoordBits-1:0] a_cx, a_cy, b_cx, b_cy, a_dx, a_dy, b_dx, b_dy;
        logic [SizeBits-1:0] a_w, a_h, b_w, b_h;
        int kind;
        kind = $urandom_range(0, 9);
        a_cx = near(1 << 22); a_cy = near(1 << 22);
        a_w = SizeBits'($urandom_range(0, 1 << 20));
        a_h = SizeBits'($urandom_range(0, 1 << 20));
        b_w = SizeBits'($urandom_range(0, 1 << 20));
        b_h = SizeBits'($urandom_range(0, 1 << 20));
        b_cx = a_cx + near(1 << 21); b_cy = a_cy + near(1 << 21);
        a_dx = b_cx - a_cx + near(1 << 20); a_dy = b_cy - a_cy + near(1 << 20);
        b_dx = near(1 << 12); b_dy = near(1 << 12);
        case (kind)
            0: begin
                // full-range noise touches every bit
                a_cx = $urandom; a_cy = $urandom; a_dx = $urandom; a_dy = $urandom;
                b_cx = $urandom; b_cy = $urandom; b_dx = $urandom; b_dy = $urandom;
                a_w = SizeBits'($urandom); a_h = SizeBits'($urandom);
                b_w = SizeBits'($urandom); b_h = SizeBits'($urandom);
            end
            1: begin
                // huge boxes around nearby centres
                a_w = SizeBits'($urandom); a_h = SizeBits'($urandom);
                b_w = SizeBits'($urandom); b_h = SizeBits'($urandom);
                a_dx = $urandom; a_dy = $urandom;
            end
            2: a_dy = b_dy;           // motion parallel to x
            3: a_dx = b_dx;           // motion parallel to y
            4: begin
                a_dx = b_dx; a_dy = b_dy;   // no relative motion
            end
            5: begin
                a_w = '0; b_w = '0;   // degenerate width
            end
            6: begin
                // corner-to-corner diagonal motion
                a_w = b_w; a_h = b_w; b_h = b_w;
                a_dx = (b_cx - a_cx) * 2; a_dy = (b_cy - a_cy) * 2;
                b_dx = '0; b_dy = '0;
            end
            default: ;
        endcase
        offer_pair(a_cx, a_cy, a_w, a_h, a_dx, a_dy, b_cx, b_cy, b_w, b_h, b_dx, b_dy);
    endtask

    // Result side: random stalls, a zero-stall phase and one long hold-off.
    initial begin
        int gap;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_outputs) begin
                m_ready = 1'b0;
                repeat (300) @(negedge aclk);
                hold_outputs = 1'b0;
            end
            gap = sender_busy ? 0 : $urandom_range(0, 18);
            if (gap > 0) begin
                m_ready = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Stimulus.
    initial begin
        logic signed [CoordBits-1:0] one, half, max_c, min_c;
        logic [SizeBits-1:0] max_s, one_s, two_s;
        one = 32'sh0001_0000; half = 32'sh0000_8000;
        max_c = 32'sh7fff_ffff; min_c = 32'sh8000_0000; max_s = '1;
        one_s = SizeBits'(one); two_s = SizeBits'(2 * one);
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // plain hit from the left at one half
        offer_pair(0, 0, one_s, one_s, 4 * one, 0, 3 * one, 0, one_s, one_s, 0, 0);
        // touching at fraction 1 exactly
        offer_pair(0, 0, one_s, one_s, 2 * one, 0, 3 * one, 0, one_s, one_s, 0, 0);
        // already overlapping and moving: no edge lies ahead within the frame, so no hit
        offer_pair(0, 0, two_s, two_s, one, 0, half, 0, two_s, two_s, 0, 0);
        // falls short
        offer_pair(0, 0, one_s, one_s, one, 0, 5 * one, 0, one_s, one_s, 0, 0);
        // moving away
        offer_pair(0, 0, one_s, one_s, -4 * one, 0, 3 * one, 0, one_s, one_s, 0, 0);
        // zero relative motion, overlapping
        offer_pair(0, 0, one_s, one_s, one, one, 0, 0, one_s, one_s, one, one);
        // grazing along an edge: parallel, no hit on that edge
        offer_pair(0, 0, one_s, one_s, 0, 4 * one, one, 3 * one, one_s, one_s, 0, 0);
        // exact corner hit on a diagonal
        offer_pair(0, 0, one_s, one_s, 4 * one, 4 * one, 3 * one, 3 * one,
                   one_s, one_s, 0, 0);
        // zero-size boxes
        offer_pair(0, 0, 0, 0, 4 * one, 0, 2 * one, 0, 0, 0, 0, 0);
        offer_pair(0, 0, 0, one_s, 4 * one, 0, 2 * one, 0, 0, one_s, 0, 0);
        // both boxes moving, vertical hit through the bottom
        offer_pair(0, 0, one_s, one_s, 0, 3 * one, 0, 4 * one, one_s, one_s, 0, -3 * one);
        // coordinate and size extremes
        offer_pair(min_c, min_c, max_s, max_s, max_c, max_c,
                   max_c, max_c, max_s, max_s, min_c, min_c);
        offer_pair(max_c, min_c, max_s, 0, min_c, max_c,
                   min_c, max_c, 0, max_s, max_c, min_c);
        offer_pair(min_c, max_c, 0, 0, 0, 0, max_c, min_c, max_s, max_s, 0, 0);
        offer_pair(max_c, max_c, max_s, max_s, max_c, min_c,
                   max_c, max_c, max_s, max_s, min_c, max_c);
        offer_pair(-1, -1, 1, 1, -1, 1, 1, 1, 1, 1, 1, -1);

        for (int n = 0; n < RandomPairs; n++) begin
            sender_busy = (n >= 150 && n < 250);
            if (n == 400) hold_outputs = 1'b1;
            offer_random_pair();
        end
        sender_busy = 1'b0;

        wait (pending == 0);
        repeat (40) @(posedge aclk);
        $display("Checked %0d results over %0d cycles, %0d of them collisions,",
                 results_seen, cycles, hits_seen);
        $display("including extremes, parallel and still motion, and a long output stall.");
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
